[sv/rrq_pkg.sv]
// Shared types, widths and constants for the radius range query table.
package rrq_pkg;

    // Field widths of the item channels.
    localparam int COORD_W = 24;
    localparam int IDX_W   = 10;
    localparam int RAD_W   = 23;
    localparam int LIM_W   = 7;

    // Derived arithmetic widths: a coordinate difference, its square,
    // the sum of two squares and the squared radius.
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int RSQ_W   = 2 * RAD_W;

    // Largest number of matches a query may return.
    localparam logic [LIM_W-1:0] MAX_MATCHES = 7'd64;

    // Opcodes of an input item.
    typedef enum logic {
        OP_SET   = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    // Controller states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic set_wr;
        logic start;
        logic scan;
        logic final_push;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_addr;
        logic is_query;
        logic q_empty;
        logic scan_stop;
        logic out_free;
    } t_ctrl_sts;

    // One result item as held in the output register.
    typedef struct packed {
        logic [IDX_W-1:0] match_index;
        logic             match_valid;
        logic             last_match;
    } t_rsp;

endpackage

[sv/rrq_req_if.sv]
// Input item channel: valid, ready and the request fields.
interface rrq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic        [rrq_pkg::IDX_W-1:0]    entity_index;
    logic signed [rrq_pkg::COORD_W-1:0]  pos_x;
    logic signed [rrq_pkg::COORD_W-1:0]  pos_z;
    logic signed [rrq_pkg::COORD_W-1:0]  center_x;
    logic signed [rrq_pkg::COORD_W-1:0]  center_z;
    logic        [rrq_pkg::RAD_W-1:0]    query_radius;
    logic        [rrq_pkg::LIM_W-1:0]    result_limit;

    modport source (
        output valid, opcode, entity_index, pos_x, pos_z, center_x, center_z,
               query_radius, result_limit,
        input  ready
    );
    modport sink (
        input  valid, opcode, entity_index, pos_x, pos_z, center_x, center_z,
               query_radius, result_limit,
        output ready
    );
endinterface

[sv/rrq_rsp_if.sv]
// Result item channel: valid, ready and the match fields.
interface rrq_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [rrq_pkg::IDX_W-1:0]  match_index;
    logic                       match_valid;
    logic                       last_match;

    modport source (
        output valid, match_index, match_valid, last_match,
        input  ready
    );
    modport sink (
        input  valid, match_index, match_valid, last_match,
        output ready
    );
endinterface

[sv/radius_range_query_table_unit.sv]
// Top level of the radius range query table: controller, datapath and channels.
// A set item with an index below NUM_SLOTS is written as it is accepted. A query reads one slot per
// cycle into a three-stage distance pipeline while no match waits on a full output register, and
// holds each match until the next one shows whether it is last; the scan stops early at the limit.
// No new item is taken while a query runs, until its final result enters the output register.
// Reset (synchronous, active low) starts a clearing pass over all NUM_SLOTS slots; no item is taken.
module radius_range_query_table_unit #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrq_req_if.sink     i_req,
    rrq_rsp_if.source   o_rsp
);

    rrq_pkg::t_ctrl_cmd w_cmd;
    rrq_pkg::t_ctrl_sts w_sts;

    // Controller.
    rrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    rrq_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_req.opcode),
        .i_entity_index (i_req.entity_index),
        .i_pos_x        (i_req.pos_x),
        .i_pos_z        (i_req.pos_z),
        .i_center_x     (i_req.center_x),
        .i_center_z     (i_req.center_z),
        .i_query_radius (i_req.query_radius),
        .i_result_limit (i_req.result_limit),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_match_index  (o_rsp.match_index),
        .o_match_valid  (o_rsp.match_valid),
        .o_last_match   (o_rsp.last_match)
    );

endmodule

[sv/rrq_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module rrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/rrq_ctrl.sv]
// Controller state machine: clearing pass, item acceptance, scan and final result.
module rrq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  rrq_pkg::t_ctrl_sts i_sts,
    output rrq_pkg::t_ctrl_cmd o_cmd
);

    rrq_pkg::t_state r_state;
    rrq_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrq_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrq_pkg::S_CLEAR: begin
                if (i_sts.last_addr) begin
                    n_state = rrq_pkg::S_IDLE;
                end
            end
            rrq_pkg::S_IDLE: begin
                if (i_req_valid && i_sts.is_query) begin
                    n_state = i_sts.q_empty ? rrq_pkg::S_FINAL : rrq_pkg::S_SCAN;
                end
            end
            rrq_pkg::S_SCAN: begin
                if (i_sts.scan_stop) begin
                    n_state = rrq_pkg::S_FINAL;
                end
            end
            rrq_pkg::S_FINAL: begin
                if (i_sts.out_free) begin
                    n_state = rrq_pkg::S_IDLE;
                end
            end
            default: n_state = rrq_pkg::S_CLEAR;
        endcase
    end

    // Outputs: handshake ready and datapath commands.
    always_comb begin
        o_req_ready      = 1'b0;
        o_cmd            = '0;
        unique case (r_state)
            rrq_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            rrq_pkg::S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.set_wr = i_req_valid && !i_sts.is_query;
                o_cmd.start  = i_req_valid && i_sts.is_query;
            end
            rrq_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            rrq_pkg::S_FINAL: begin
                o_cmd.final_push = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

[sv/rrq_dpath.sv]
// Datapath: slot memory, scan pipeline, distance compare, pending match and output register.
module rrq_dpath #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rrq_pkg::t_ctrl_cmd                 i_cmd,
    output rrq_pkg::t_ctrl_sts                 o_sts,
    input  logic                               i_opcode,
    input  logic        [rrq_pkg::IDX_W-1:0]   i_entity_index,
    input  logic signed [rrq_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [rrq_pkg::COORD_W-1:0] i_pos_z,
    input  logic signed [rrq_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [rrq_pkg::COORD_W-1:0] i_center_z,
    input  logic        [rrq_pkg::RAD_W-1:0]   i_query_radius,
    input  logic        [rrq_pkg::LIM_W-1:0]   i_result_limit,
    output logic                               o_rsp_valid,
    input  logic                               i_rsp_ready,
    output logic        [rrq_pkg::IDX_W-1:0]   o_match_index,
    output logic                               o_match_valid,
    output logic                               o_last_match
);

    localparam int AW     = $clog2(NUM_SLOTS);
    localparam int CMP_W  = rrq_pkg::IDX_W > AW + 1 ? rrq_pkg::IDX_W : AW + 1;
    localparam int MEM_W  = 2 * rrq_pkg::COORD_W + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SLOTS - 1);

    // Query registers.
    logic signed [rrq_pkg::COORD_W-1:0] r_cx;
    logic signed [rrq_pkg::COORD_W-1:0] r_cz;
    logic        [rrq_pkg::RSQ_W-1:0]   r_rad_sq;
    logic        [rrq_pkg::LIM_W-1:0]   r_limit;
    logic        [rrq_pkg::LIM_W-1:0]   r_count;

    // Address counter, shared by the clearing pass and the scan.
    logic [AW-1:0] r_addr;
    logic          r_issuing;

    // Pipeline stages.
    logic                              r_s1_valid;
    logic [AW-1:0]                     r_s1_idx;
    logic                              r_s2_valid;
    logic [AW-1:0]                     r_s2_idx;
    logic signed [rrq_pkg::DIFF_W-1:0] r_s2_dx;
    logic signed [rrq_pkg::DIFF_W-1:0] r_s2_dz;
    logic                              r_s3_valid;
    logic [AW-1:0]                     r_s3_idx;
    logic        [rrq_pkg::SQ_W-1:0]   r_s3_sqx;
    logic        [rrq_pkg::SQ_W-1:0]   r_s3_sqz;

    // Pending match and output register.
    logic          r_pend_valid;
    logic [AW-1:0] r_pend_idx;
    logic          r_out_valid;
    rrq_pkg::t_rsp r_out;

    logic                              w_we;
    logic [AW-1:0]                     w_waddr;
    logic [MEM_W-1:0]                  w_wdata;
    logic [MEM_W-1:0]                  w_rdata;
    logic                              w_set_ok;
    logic                              w_re;
    logic        [rrq_pkg::RSQ_W-1:0]  w_rsq;
    logic        [rrq_pkg::LIM_W-1:0]  w_lim;
    logic signed [rrq_pkg::COORD_W-1:0] w_mx;
    logic signed [rrq_pkg::COORD_W-1:0] w_mz;
    logic signed [2*rrq_pkg::DIFF_W-1:0] w_px;
    logic signed [2*rrq_pkg::DIFF_W-1:0] w_pz;
    logic        [rrq_pkg::SUM_W-1:0]  w_sum;
    logic                              w_hit;
    logic                              w_out_free;
    logic                              w_stall;
    logic                              w_adv;
    logic        [rrq_pkg::LIM_W-1:0]  w_count_inc;
    logic                              w_limit_hit;
    logic                              w_scan_push;

    // Set items below the slot count are written; the clearing pass writes zeros.
    assign w_set_ok = CMP_W'(i_entity_index) < CMP_W'(NUM_SLOTS);
    assign w_we     = i_cmd.clear || (i_cmd.set_wr && w_set_ok);
    assign w_waddr  = i_cmd.clear ? r_addr : AW'(i_entity_index);
    assign w_wdata  = i_cmd.clear ? '0 : {1'b1, i_pos_x, i_pos_z};

    assign w_re = w_adv && r_issuing;

    rrq_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Query setup: squared radius and clamped limit.
    assign w_rsq = i_query_radius * i_query_radius;
    assign w_lim = (i_result_limit > rrq_pkg::MAX_MATCHES) ? rrq_pkg::MAX_MATCHES
                                                            : i_result_limit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cx     <= i_center_x;
            r_cz     <= i_center_z;
            r_rad_sq <= w_rsq;
            r_limit  <= w_lim;
        end
    end

    // Distance arithmetic of the stages.
    assign w_mx  = w_rdata[MEM_W-2 -: rrq_pkg::COORD_W];
    assign w_mz  = w_rdata[rrq_pkg::COORD_W-1:0];
    assign w_px  = r_s2_dx * r_s2_dx;
    assign w_pz  = r_s2_dz * r_s2_dz;
    assign w_sum = {1'b0, r_s3_sqx} + {1'b0, r_s3_sqz};
    assign w_hit = r_s3_valid && (w_sum <= rrq_pkg::SUM_W'(r_rad_sq));

    // The scan stalls only when a match meets a full output register.
    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign w_stall     = w_hit && !w_out_free;
    assign w_adv       = i_cmd.scan && !w_stall;
    assign w_count_inc = rrq_pkg::LIM_W'(r_count + 1'b1);
    assign w_limit_hit = w_hit && (w_count_inc == r_limit);
    assign w_scan_push = w_adv && w_hit && r_pend_valid;

    // Address counter and issue flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_issuing <= 1'b0;
        end else if (i_cmd.clear) begin
            r_addr <= (r_addr == LAST_ADDR) ? '0 : AW'(r_addr + 1'b1);
        end else if (i_cmd.start) begin
            r_addr    <= '0;
            r_issuing <= (i_query_radius != '0) && (w_lim != '0);
        end else if (w_adv && r_issuing) begin
            r_addr <= AW'(r_addr + 1'b1);
            if (r_addr == LAST_ADDR) begin
                r_issuing <= 1'b0;
            end
        end
    end

    // Stage valids; inactive slots drop out at the second stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= r_issuing;
            r_s2_valid <= r_s1_valid && w_rdata[MEM_W-1];
            r_s3_valid <= r_s2_valid;
        end
    end

    // Stage payload: differences, then squares.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_idx <= r_addr;
            r_s2_idx <= r_s1_idx;
            r_s2_dx  <= $signed({w_mx[rrq_pkg::COORD_W-1], w_mx})
                      - $signed({r_cx[rrq_pkg::COORD_W-1], r_cx});
            r_s2_dz  <= $signed({w_mz[rrq_pkg::COORD_W-1], w_mz})
                      - $signed({r_cz[rrq_pkg::COORD_W-1], r_cz});
            r_s3_idx <= r_s2_idx;
            r_s3_sqx <= w_px[rrq_pkg::SQ_W-1:0];
            r_s3_sqz <= w_pz[rrq_pkg::SQ_W-1:0];
        end
    end

    // Pending match: held back until the next match or the end shows if it is last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start || i_cmd.final_push) begin
            r_pend_valid <= 1'b0;
            r_count      <= '0;
        end else if (w_adv && w_hit) begin
            r_pend_valid <= 1'b1;
            r_count      <= w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_hit) begin
            r_pend_idx <= r_s3_idx;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_scan_push || i_cmd.final_push) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_push) begin
            r_out.match_index <= rrq_pkg::IDX_W'(r_pend_idx);
            r_out.match_valid <= 1'b1;
            r_out.last_match  <= 1'b0;
        end else if (i_cmd.final_push) begin
            r_out.match_index <= r_pend_valid ? rrq_pkg::IDX_W'(r_pend_idx) : '0;
            r_out.match_valid <= r_pend_valid;
            r_out.last_match  <= 1'b1;
        end
    end

    // Status to the controller.
    assign o_sts.last_addr = (r_addr == LAST_ADDR);
    assign o_sts.is_query  = (i_opcode == rrq_pkg::OP_QUERY);
    assign o_sts.q_empty   = (i_query_radius == '0) || (w_lim == '0);
    assign o_sts.scan_stop = w_adv && ((r_s3_valid && (r_s3_idx == LAST_ADDR))
                                       || w_limit_hit
                                       || (!r_issuing && !r_s1_valid
                                           && !r_s2_valid && !r_s3_valid));
    assign o_sts.out_free  = w_out_free;

    assign o_rsp_valid   = r_out_valid;
    assign o_match_index = r_out.match_index;
    assign o_match_valid = r_out.match_valid;
    assign o_last_match  = r_out.last_match;

    // The match count never passes the limit of the query.
    a_count_le_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_count <= r_limit))
        else $error("match count above limit");

    // An empty answer is always the final result.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.match_valid) |-> r_out.last_match)
        else $error("empty answer not marked last");

    // A new query starts with no pending match.
    a_start_clears_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> !r_pend_valid)
        else $error("pending match survived query start");

    // While issuing, the address counter is one slot ahead of the first stage.
    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_s1_valid && r_issuing) |-> (r_addr == AW'(r_s1_idx + 1'b1)))
        else $error("scan stages out of order");

    // A stall holds the final stage.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && w_stall) |=> (r_s3_valid && $stable(r_s3_idx)))
        else $error("stalled match lost");

endmodule
